### hw/rtl/mbf_pkg.sv
`timescale 1ns / 1ps

package mbf_pkg;

    // Frame constants
    localparam int unsigned FRAME_LEN = 8;
    localparam logic [7:0]  WRITE_FN  = 8'h06;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;

    // Command codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Line count that selects the one-phase count
    localparam logic [7:0] LINE_ONE_PHASE = 8'd1;

    // Register indexes
    localparam logic [1:0] REG_READ_FN    = 2'd0;
    localparam logic [1:0] REG_READ_START = 2'd1;
    localparam logic [1:0] REG_ONE_PHASE  = 2'd2;
    localparam logic [1:0] REG_THREE_PHASE = 2'd3;

    // Byte positions within the frame
    localparam logic [2:0] BYTE_DEV     = 3'd0;
    localparam logic [2:0] BYTE_FN      = 3'd1;
    localparam logic [2:0] BYTE_REG_HI  = 3'd2;
    localparam logic [2:0] BYTE_REG_LO  = 3'd3;
    localparam logic [2:0] BYTE_CNT_HI  = 3'd4;
    localparam logic [2:0] BYTE_CNT_LO  = 3'd5;
    localparam logic [2:0] BYTE_CRC_LO  = 3'd6;
    localparam logic [2:0] BYTE_CRC_HI  = 3'd7;

    // Configuration register set
    typedef struct packed {
        logic [7:0]  read_fn;
        logic [15:0] read_start;
        logic [15:0] one_phase;
        logic [15:0] three_phase;
    } cfg_t;

    // Classified frame header: the six bytes covered by the CRC
    typedef struct packed {
        logic [7:0]  dev;
        logic [7:0]  fn;
        logic [15:0] regaddr;
        logic [15:0] cnt;
    } hdr_t;

    // Queue head as seen by the serialiser
    typedef struct packed {
        logic valid;
        hdr_t hdr;
    } q_head_t;

    // One byte step of CRC-16/MODBUS
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### hw/rtl/mbf_regs.sv
`timescale 1ns / 1ps

module mbf_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output mbf_pkg::cfg_t cfg
);
    import mbf_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] index;

    assign wr_en  = psel && penable && pwrite;
    assign index  = paddr[3:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write the addressed register on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.read_fn     <= 8'd3;
            cfg_reg.read_start  <= 16'd0;
            cfg_reg.one_phase   <= 16'd0;
            cfg_reg.three_phase <= 16'd0;
        end
        else if (wr_en)
        begin
            case (index)
                REG_READ_FN:     cfg_reg.read_fn     <= pwdata[7:0];
                REG_READ_START:  cfg_reg.read_start  <= pwdata[15:0];
                REG_ONE_PHASE:   cfg_reg.one_phase   <= pwdata[15:0];
                REG_THREE_PHASE: cfg_reg.three_phase <= pwdata[15:0];
                default:         cfg_reg.read_fn     <= cfg_reg.read_fn;
            endcase
        end
    end

    // Return the addressed register, zero extended
    always_comb
    begin
        case (index)
            REG_READ_FN:     prdata = {24'd0, cfg_reg.read_fn};
            REG_READ_START:  prdata = {16'd0, cfg_reg.read_start};
            REG_ONE_PHASE:   prdata = {16'd0, cfg_reg.one_phase};
            REG_THREE_PHASE: prdata = {16'd0, cfg_reg.three_phase};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

### hw/rtl/mbf_front.sv
`timescale 1ns / 1ps

module mbf_front (
    input  logic          command,
    input  logic [7:0]    device_addr,
    input  logic [7:0]    line_count,
    input  logic [15:0]   reg_addr,
    input  logic [15:0]   reg_value,
    input  mbf_pkg::cfg_t cfg,
    output mbf_pkg::hdr_t hdr
);
    import mbf_pkg::*;

    // Classify the request and pick the header fields
    always_comb
    begin
        hdr.dev = device_addr;
        if (command == CMD_WRITE)
        begin
            hdr.fn      = WRITE_FN;
            hdr.regaddr = reg_addr;
            hdr.cnt     = reg_value;
        end
        else
        begin
            hdr.fn      = cfg.read_fn;
            hdr.regaddr = cfg.read_start;
            hdr.cnt     = (line_count == LINE_ONE_PHASE) ? cfg.one_phase : cfg.three_phase;
        end
    end

endmodule

### hw/rtl/mbf_queue.sv
`timescale 1ns / 1ps

module mbf_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mbf_pkg::hdr_t    push_hdr,
    output logic             full,
    input  logic             pop,
    output mbf_pkg::q_head_t head
);
    import mbf_pkg::*;

    hdr_t       entry_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign do_push    = push && !full;
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.hdr   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    // Store the header
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_hdr;
    end

endmodule

### hw/rtl/mbf_back.sv
`timescale 1ns / 1ps

module mbf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  mbf_pkg::q_head_t head,
    output logic             pop,
    output logic             frame_valid,
    input  logic             frame_ready,
    output logic [7:0]       frame_byte,
    output logic             last_byte
);
    import mbf_pkg::*;

    hdr_t        hdr_reg, hdr_next;
    logic [15:0] crc_reg, crc_next;
    logic [2:0]  idx_reg, idx_next;
    logic        busy_reg, busy_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic        out_free, emit;

    assign out_free    = !valid_reg || frame_ready;
    assign emit        = out_free && (busy_reg || head.valid);
    assign pop         = out_free && !busy_reg && head.valid;
    assign frame_valid = valid_reg;
    assign frame_byte  = byte_reg;
    assign last_byte   = last_reg;

    // Pick the next byte and fold header bytes into the CRC
    always_comb
    begin
        hdr_next   = hdr_reg;
        crc_next   = crc_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !frame_ready;
        if (emit)
        begin
            valid_next = 1'b1;
            last_next  = 1'b0;
            if (!busy_reg)
            begin
                // start a new frame straight from the queue head
                hdr_next  = head.hdr;
                byte_next = head.hdr.dev;
                crc_next  = crc_byte(CRC_INIT, head.hdr.dev);
                idx_next  = BYTE_FN;
                busy_next = 1'b1;
            end
            else
            begin
                case (idx_reg)
                    BYTE_DEV:    byte_next = hdr_reg.dev;
                    BYTE_FN:     byte_next = hdr_reg.fn;
                    BYTE_REG_HI: byte_next = hdr_reg.regaddr[15:8];
                    BYTE_REG_LO: byte_next = hdr_reg.regaddr[7:0];
                    BYTE_CNT_HI: byte_next = hdr_reg.cnt[15:8];
                    BYTE_CNT_LO: byte_next = hdr_reg.cnt[7:0];
                    BYTE_CRC_LO: byte_next = crc_reg[7:0];
                    BYTE_CRC_HI: byte_next = crc_reg[15:8];
                    default:     byte_next = 8'h00;
                endcase
                if (idx_reg < BYTE_CRC_LO)
                    crc_next = crc_byte(crc_reg, byte_next);
                idx_next = idx_reg + 3'd1;
                if (idx_reg == BYTE_CRC_HI)
                begin
                    last_next = 1'b1;
                    busy_next = 1'b0;
                end
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            idx_reg   <= BYTE_DEV;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        hdr_reg  <= hdr_next;
        crc_reg  <= crc_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

endmodule

### hw/rtl/modbus_rtu_request_framer_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake                     Payload
// request   req_valid / req_ready         command, device_addr, line_count, reg_addr, reg_value
// frame     frame_valid / frame_ready     frame_byte, last_byte
// config    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// Each request gives eight frame bytes, one per cycle while frame_ready is high; the
// one-byte-per-cycle serialiser and CRC finish a frame before taking the next request. When
// idle, an accepted request goes into the queue, then into the output register as the first
// byte. A two-entry queue takes requests while the serialiser is busy or the output stalls.
// Reset clears the queue, serialiser and output register; registers go to documented values.
module modbus_rtu_request_framer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        command,
    input  logic [7:0]  device_addr,
    input  logic [7:0]  line_count,
    input  logic [15:0] reg_addr,
    input  logic [15:0] reg_value,
    output logic        frame_valid,
    input  logic        frame_ready,
    output logic [7:0]  frame_byte,
    output logic        last_byte
);
    import mbf_pkg::*;

    cfg_t    cfg;
    hdr_t    hdr;
    q_head_t head;
    logic    q_full;
    logic    pop;

    assign req_ready = !q_full;

    mbf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbf_front u_front (
        .command     (command),
        .device_addr (device_addr),
        .line_count  (line_count),
        .reg_addr    (reg_addr),
        .reg_value   (reg_value),
        .cfg         (cfg),
        .hdr         (hdr)
    );

    mbf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (req_valid),
        .push_hdr (hdr),
        .full     (q_full),
        .pop      (pop),
        .head     (head)
    );

    mbf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_byte  (frame_byte),
        .last_byte   (last_byte)
    );

endmodule

### hw/rtl/mbf_checker.sv
`timescale 1ns / 1ps

module mbf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pready,
    input logic       req_valid,
    input logic       req_ready,
    input logic       frame_valid,
    input logic       frame_ready,
    input logic [7:0] frame_byte,
    input logic       last_byte
);
    logic [2:0] pos_reg;
    logic [3:0] pending_reg;
    logic       req_acc, byte_acc, frame_done;

    assign req_acc    = req_valid && req_ready;
    assign byte_acc   = frame_valid && frame_ready;
    assign frame_done = byte_acc && last_byte;

    // Track byte position and requests not yet fully sent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 3'd0;
            pending_reg <= 4'd0;
        end
        else
        begin
            if (byte_acc)
                pos_reg <= pos_reg + 3'd1;
            if (req_acc && !frame_done)
                pending_reg <= pending_reg + 4'd1;
            else if (frame_done && !req_acc)
                pending_reg <= pending_reg - 4'd1;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=> frame_valid && $stable(frame_byte) && $stable(last_byte))
        else $error("frame byte changed while stalled");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        byte_acc |-> (last_byte == (pos_reg == 3'd7)))
        else $error("last byte flag out of place");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> (pending_reg != 4'd0))
        else $error("frame byte without a request");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd4)
        else $error("too many requests in flight");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind modbus_rtu_request_framer_unit mbf_checker u_mbf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pready      (pready),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame_byte  (frame_byte),
    .last_byte   (last_byte)
);

### dv/modbus_rtu_request_framer_unit_test.sv
`timescale 1ns / 1ps

module modbus_rtu_request_framer_unit_test;

    import mbf_pkg::*;

    localparam int LONG_HOLD      = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct {
        logic        cmd;
        logic [7:0]  dev;
        logic [7:0]  line;
        logic [15:0] addr;
        logic [15:0] value;
    } request_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } frame_beat_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid   = 1'b0;
    logic        req_ready;
    logic        command     = 1'b0;
    logic [7:0]  device_addr = '0;
    logic [7:0]  line_count  = '0;
    logic [15:0] reg_addr    = '0;
    logic [15:0] reg_value   = '0;
    logic        frame_valid;
    logic        frame_ready = 1'b0;
    logic [7:0]  frame_byte;
    logic        last_byte;

    // Local copy of the register set
    logic [7:0]  cfg_read_fn     = 8'd3;
    logic [15:0] cfg_read_start  = '0;
    logic [15:0] cfg_one_phase   = '0;
    logic [15:0] cfg_three_phase = '0;

    request_t    pending_requests[$];
    frame_beat_t expected_frame_bytes[$];
    request_t    offered;
    frame_beat_t want;
    bit          no_gaps      = 1'b0;
    int          gap_left     = 0;
    int          stall_left   = 0;
    int          results_seen = 0;
    int          quiet_cycles = 0;
    int          mismatches   = 0;

    modbus_rtu_request_framer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .command     (command),
        .device_addr (device_addr),
        .line_count  (line_count),
        .reg_addr    (reg_addr),
        .reg_value   (reg_value),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_byte  (frame_byte),
        .last_byte   (last_byte)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Build the eight bytes a request should produce and queue them
    function automatic void compute_rtu_frame(request_t r);
        logic [7:0]  hdr [0:5];
        logic [7:0]  fn;
        logic [15:0] regf;
        logic [15:0] cnt;
        logic [15:0] crc;
        int          k;
        int          b;
        if (r.cmd == CMD_WRITE)
        begin
            fn   = WRITE_FN;
            regf = r.addr;
            cnt  = r.value;
        end
        else
        begin
            fn   = cfg_read_fn;
            regf = cfg_read_start;
            cnt  = (r.line == LINE_ONE_PHASE) ? cfg_one_phase : cfg_three_phase;
        end
        hdr[0] = r.dev;
        hdr[1] = fn;
        hdr[2] = regf[15:8];
        hdr[3] = regf[7:0];
        hdr[4] = cnt[15:8];
        hdr[5] = cnt[7:0];
        // CRC-16/MODBUS, reflected, shifting out the low bit
        crc = CRC_INIT;
        for (k = 0; k < 6; k++)
        begin
            crc[7:0] = crc[7:0] ^ hdr[k];
            for (b = 0; b < 8; b++)
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            expected_frame_bytes.push_back('{data: hdr[k], last: 1'b0});
        end
        expected_frame_bytes.push_back('{data: crc[7:0], last: 1'b0});
        expected_frame_bytes.push_back('{data: crc[15:8], last: 1'b1});
    endfunction

    function automatic void queue_request(logic cmd, logic [7:0] dev, logic [7:0] line,
                                          logic [15:0] addr, logic [15:0] value);
        request_t r;
        r.cmd   = cmd;
        r.dev   = dev;
        r.line  = line;
        r.addr  = addr;
        r.value = value;
        pending_requests.push_back(r);
    endfunction

    // Setup cycle, then access cycle; the register takes the data at the access edge
    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_READ_FN:     cfg_read_fn     = data[7:0];
            REG_READ_START:  cfg_read_start  = data[15:0];
            REG_ONE_PHASE:   cfg_one_phase   = data[15:0];
            REG_THREE_PHASE: cfg_three_phase = data[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [31:0] fn, input logic [31:0] start,
                                  input logic [31:0] one, input logic [31:0] three);
        write_register(REG_READ_FN, fn);
        write_register(REG_READ_START, start);
        write_register(REG_ONE_PHASE, one);
        write_register(REG_THREE_PHASE, three);
        @(negedge clk);
    endtask

    // Wait until every request is taken and every frame byte has come back
    task automatic drain;
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || req_valid || expected_frame_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                compute_rtu_frame(offered);
                gap_left = no_gaps ? 0 : $urandom_range(0, 9);
            end
            if (!req_valid || req_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    offered = pending_requests.pop_front();
                    command     <= offered.cmd;
                    device_addr <= offered.dev;
                    line_count  <= offered.line;
                    reg_addr    <= offered.addr;
                    reg_value   <= offered.value;
                    req_valid   <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Frame monitor and output back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            frame_ready <= 1'b0;
        end
        else
        begin
            if (frame_valid && frame_ready)
            begin
                if (expected_frame_bytes.size() == 0)
                begin
                    $error("frame_byte: expected none, got %0h", frame_byte);
                    mismatches++;
                end
                else
                begin
                    want = expected_frame_bytes.pop_front();
                    if (frame_byte !== want.data)
                    begin
                        $error("frame_byte: expected %0h, got %0h", want.data, frame_byte);
                        mismatches++;
                    end
                    if (last_byte !== want.last)
                    begin
                        $error("last_byte: expected %0b, got %0b", want.last, last_byte);
                        mismatches++;
                    end
                end
                results_seen++;
                // Hold off for a long stretch now and then so the block backs up
                if (results_seen == 30 || results_seen == 1000)
                    stall_left = LONG_HOLD;
                else
                    stall_left = no_gaps ? 0 : $urandom_range(0, 9);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            frame_ready <= (stall_left == 0);
        end
    end

    // Drop out if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (frame_valid && frame_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        request_t r;
        int       ph;
        int       n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values of the registers; write fields ignored on reads and vice versa
        queue_request(CMD_WRITE, 8'h00, 8'h00, 16'h0000, 16'h0000);
        queue_request(CMD_WRITE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        queue_request(CMD_WRITE, 8'h5A, 8'h01, 16'h1234, 16'hABCD);
        queue_request(CMD_READ,  8'h01, 8'h01, 16'hFFFF, 16'hFFFF);
        queue_request(CMD_READ,  8'hFF, 8'h00, 16'hFFFF, 16'h0000);
        queue_request(CMD_READ,  8'h00, 8'h02, 16'h0000, 16'hFFFF);
        queue_request(CMD_READ,  8'h11, 8'hFF, 16'h8001, 16'h7FFF);
        queue_request(CMD_WRITE, 8'h01, 8'h00, 16'h8000, 16'h7FFF);
        drain();

        // All registers at their top values, with junk above the register widths
        apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(CMD_READ,  8'hAA, 8'h01, 16'h0000, 16'h0000);
        queue_request(CMD_READ,  8'h55, 8'h00, 16'h0000, 16'h0000);
        queue_request(CMD_READ,  8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        queue_request(CMD_READ,  8'h00, 8'h02, 16'h1111, 16'h2222);
        queue_request(CMD_WRITE, 8'h07, 8'h01, 16'h00FF, 16'hFF00);
        queue_request(CMD_WRITE, 8'hFE, 8'h00, 16'h0001, 16'h0100);
        drain();

        // All registers at zero, again with junk in the upper bits
        apply_settings(32'hFFFF_FF00, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
        queue_request(CMD_READ,  8'h00, 8'h01, 16'hFFFF, 16'hFFFF);
        queue_request(CMD_READ,  8'hFF, 8'h03, 16'hFFFF, 16'hFFFF);
        queue_request(CMD_WRITE, 8'h00, 8'hFF, 16'h0000, 16'h0000);
        drain();

        // Distinct counts so a wrong phase selection shows up
        apply_settings({24'h0, WRITE_FN}, 32'h0000_8001, 32'h0000_1234, 32'h0000_FEDC);
        queue_request(CMD_READ,  8'h3C, 8'h01, 16'h0000, 16'h0000);
        queue_request(CMD_READ,  8'hC3, 8'h00, 16'h0000, 16'h0000);
        queue_request(CMD_READ,  8'h81, 8'h81, 16'h0000, 16'h0000);
        queue_request(CMD_WRITE, 8'h80, 8'h01, 16'h5555, 16'hAAAA);
        drain();

        // Random requests under random settings; one phase runs with no idling
        for (ph = 0; ph < 4; ph++)
        begin
            apply_settings($urandom, $urandom, $urandom, $urandom);
            no_gaps = (ph == 2);
            for (n = 0; n < 40; n++)
            begin
                r.cmd   = 1'($urandom_range(0, 1));
                r.dev   = 8'($urandom);
                r.line  = ($urandom_range(0, 2) == 0) ? LINE_ONE_PHASE : 8'($urandom);
                r.addr  = 16'($urandom);
                r.value = 16'($urandom);
                pending_requests.push_back(r);
            end
            drain();
            no_gaps = 1'b0;
        end

        if (mismatches == 0 && expected_frame_bytes.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
